[sv/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by the front, queue, back and top-level modules.
package u8u16_pkg;

  // Substitution unit for invalid input
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // One classified byte: up to three code units with their flags
  typedef struct packed {
    logic [2:0][15:0] unit;   // units in output order, unit[0] first
    logic [2:0]       rep;    // substitution flag per unit
    logic [1:0]       count;  // number of valid units, 0 to 3
    logic             fin;    // byte closed the string
  } job_t;

endpackage

[sv/u8u16_front.sv]
// Front end: holds the open UTF-8 sequence and turns each accepted byte into
// a job of zero to three UTF-16 units. Depends on u8u16_pkg.
module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              string_end,
  output logic              push,
  output u8u16_pkg::job_t   job
);

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_PAIR_BASE = 21'h10000;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

  // Sequence length from the lead byte, LEN_NONE for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = LEN_1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = LEN_2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = LEN_3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = LEN_4;
    end else begin
      len = LEN_NONE;
    end
    return len;
  endfunction

  // Single byte with nothing after it: ASCII passes, anything else is replaced
  function automatic logic [16:0] lone_unit(input logic [7:0] b);
    logic [16:0] r;
    if (!b[7]) begin
      r = {1'b0, 8'h00, b};
    end else begin
      r = {1'b1, u8u16_pkg::REPL_UNIT};
    end
    return r;
  endfunction

  logic [7:0] held [3];
  logic [2:0] exp_len;
  logic [1:0] held_cnt;
  logic [2:0] exp_len_next;
  logic [1:0] held_cnt_next;
  logic       store;

  logic [7:0]  seq [4];
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        seq_open;
  logic        seq_fits;
  logic [2:0]  tail_len;
  logic [16:0] lone_b;
  logic [16:0] lone_x;
  logic [16:0] lone_y;

  // Line up the held bytes with the incoming byte after them
  always_comb begin
    seq[0] = (held_cnt != 2'd0) ? held[0] : data_byte;
    seq[1] = (held_cnt > 2'd1)  ? held[1] : data_byte;
    seq[2] = (held_cnt > 2'd2)  ? held[2] : data_byte;
    seq[3] = data_byte;
  end

  assign seq_open = (exp_len != LEN_NONE);
  assign seq_fits = seq_open && (({1'b0, held_cnt} + 3'd1) >= exp_len);
  assign tail_len = lead_len(seq[1]);
  assign lone_b   = lone_unit(data_byte);
  assign lone_x   = lone_unit(seq[1]);
  assign lone_y   = lone_unit(seq[2]);

  // Assemble the code point of a complete open sequence
  always_comb begin
    unique case (exp_len)
      LEN_2:   cp = {10'b0, seq[0][4:0], seq[1][5:0]};
      LEN_3:   cp = {5'b0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      LEN_4:   cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      default: cp = {13'b0, seq[0]};
    endcase
  end

  assign cp_off = cp - CP_PAIR_BASE;

  // Classify the byte and build its job
  always_comb begin
    job           = '0;
    job.fin       = string_end;
    exp_len_next  = exp_len;
    held_cnt_next = held_cnt;
    store         = 1'b0;
    priority if (seq_fits) begin
      // Sequence complete: one unit, a surrogate pair, or out of range
      if (cp[20:16] == 5'd0) begin
        job.unit[0] = cp[15:0];
        job.count   = 2'd1;
      end else if (cp <= CP_MAX) begin
        job.unit[0] = SURR_HI_BASE + {6'b0, cp_off[19:10]};
        job.unit[1] = SURR_LO_BASE + {6'b0, cp_off[9:0]};
        job.count   = 2'd2;
      end else begin
        job.unit[0] = u8u16_pkg::REPL_UNIT;
        job.rep[0]  = 1'b1;
        job.count   = 2'd1;
      end
      exp_len_next  = LEN_NONE;
      held_cnt_next = 2'd0;
    end else if (string_end && seq_open) begin
      // Truncated at string end: replace the lead, rescan what follows it
      job.unit[0] = u8u16_pkg::REPL_UNIT;
      job.rep[0]  = 1'b1;
      if (held_cnt == 2'd1) begin
        {job.rep[1], job.unit[1]} = lone_x;
        job.count = 2'd2;
      end else if (tail_len == LEN_2) begin
        job.unit[1] = {5'b0, seq[1][4:0], seq[2][5:0]};
        job.count   = 2'd2;
      end else begin
        {job.rep[1], job.unit[1]} = (tail_len == LEN_1) ? lone_x
                                  : {1'b1, u8u16_pkg::REPL_UNIT};
        {job.rep[2], job.unit[2]} = lone_y;
        job.count = 2'd3;
      end
      exp_len_next  = LEN_NONE;
      held_cnt_next = 2'd0;
    end else if (string_end) begin
      // Final byte with no sequence open
      {job.rep[0], job.unit[0]} = lone_b;
      job.count = 2'd1;
    end else if (!seq_open) begin
      // New lead byte: emit ASCII or replacement, or open a sequence
      if (lead_len(data_byte) == LEN_1) begin
        job.unit[0] = {8'h00, data_byte};
        job.count   = 2'd1;
      end else if (lead_len(data_byte) == LEN_NONE) begin
        job.unit[0] = u8u16_pkg::REPL_UNIT;
        job.rep[0]  = 1'b1;
        job.count   = 2'd1;
      end else begin
        store         = 1'b1;
        exp_len_next  = lead_len(data_byte);
        held_cnt_next = 2'd1;
      end
    end else begin
      // Next byte of an unfinished sequence: hold it
      store         = 1'b1;
      held_cnt_next = held_cnt + 2'd1;
    end
  end

  assign push = accept && (job.count != 2'd0);

  // Advance sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len  <= LEN_NONE;
      held_cnt <= 2'd0;
    end else if (accept) begin
      exp_len  <= exp_len_next;
      held_cnt <= held_cnt_next;
    end
  end

  // Hold sequence bytes
  always_ff @(posedge clk) begin
    if (accept && store) begin
      held[held_cnt] <= data_byte;
    end
  end

endmodule

[sv/u8u16_queue.sv]
// Job queue between the front and back ends, built from registers.
// Depends on u8u16_pkg for the job type.
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  u8u16_pkg::job_t              wr_data,
  input  logic                         pop,
  output u8u16_pkg::job_t              rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  u8u16_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign full    = (level == LVL_W'(DEPTH));
  assign empty   = (level == '0);
  assign rd_data = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  // Store jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/u8u16_back.sv]
// Back end: walks the units of the head job into the output register.
// Depends on u8u16_pkg for the job type.
module u8u16_back (
  input  logic             clk,
  input  logic             rst,
  input  u8u16_pkg::job_t  head,
  input  logic             head_valid,
  output logic             pop,
  output logic             unit_valid,
  input  logic             unit_stall,
  output logic [15:0]      code_unit,
  output logic             run_last,
  output logic             replaced,
  output logic             is_final
);

  logic [1:0] idx;
  logic       load;
  logic       job_done;

  assign load     = head_valid && (!unit_valid || !unit_stall);
  assign job_done = ((idx + 2'd1) == head.count);
  assign pop      = load && job_done;

  // Advance the unit index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load) begin
        unit_valid <= 1'b1;
        idx        <= job_done ? 2'd0 : idx + 2'd1;
      end else if (!unit_stall) begin
        unit_valid <= 1'b0;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_unit <= head.unit[idx];
      replaced  <= head.rep[idx];
      run_last  <= job_done;
      is_final  <= job_done && head.fin;
    end
  end

endmodule

[sv/utf8_to_utf16_transcoder_core.sv]
// UTF-8 to UTF-16 transcoder, top level.
// Instantiates u8u16_front, u8u16_queue and u8u16_back; uses u8u16_pkg.
//
// Input channel: one UTF-8 byte per request (data_byte), with string_end
// set on the last byte of a string. A request is taken at a rising edge
// with byte_valid high and byte_stall low.
// Output channel: one UTF-16 code unit per request (code_unit), taken at
// a rising edge with unit_valid high and unit_stall low. run_last marks
// the last unit caused by an input byte, replaced marks a U+FFFD
// substitution, is_final marks the last unit of a string.
// A byte produces zero to three units. The first one is registered in the
// job queue and then in the output register. Bytes are taken one per cycle
// while the output side keeps up; the back end sends one unit per cycle
// while unit_stall is low, so bytes that produce two or three units fill the
// job queue of QUEUE_DEPTH entries and byte_stall rises when it is full.
// A stalled output holds its unit; the front keeps taking bytes until the
// queue fills.
// Reset (rst, synchronous) empties the queue, drops the output unit and
// closes any open sequence.
module utf8_to_utf16_transcoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  output logic        unit_valid,
  input  logic        unit_stall,
  output logic [15:0] code_unit,
  output logic        run_last,
  output logic        replaced,
  output logic        is_final
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  u8u16_pkg::job_t  fe_job;
  u8u16_pkg::job_t  q_head;
  logic             accept;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [LVL_W-1:0] q_level;

  // Hold bytes while the job queue is full
  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .string_end (string_end),
    .push       (q_push),
    .job        (fe_job)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (fe_job),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty),
    .level   (q_level)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .replaced   (replaced),
    .is_final   (is_final)
  );

  // Queue never overflows
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("job queue level above depth");

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into full job queue");

  // Substituted units carry the replacement character
  a_repl_unit: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && replaced) |-> (code_unit == u8u16_pkg::REPL_UNIT))
    else $error("replaced unit is not U+FFFD");

  // End of string closes the run of its byte
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && is_final) |-> run_last)
    else $error("final unit without run_last");

endmodule
